// ===== hw/rtl/ricl_pkg.sv =====
// Shared types and constants for the rigidity inlier clique search.
`default_nettype none
package ricl_pkg;

   localparam int COORD_W    = 24;
   localparam int TOL_W      = 26;
   localparam int NODE_W     = 6;
   localparam int MAG_W      = 24;
   localparam int PROD_W     = 48;
   localparam int SUM_W      = 50;
   localparam int ROOT_W     = 25;
   localparam int ROOT_STEPS = 25;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [SUM_W-1:0] ROOT_BIT_INIT = SUM_W'(1) << (SUM_W - 2);

   // register index in the csr map
   localparam logic [0:0] REG_TOLERANCE = 1'b0;
   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(256);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type cx;
      coord_type cy;
      coord_type cz;
      coord_type px;
      coord_type py;
      coord_type pz;
   } point_type;

   typedef struct packed {
      logic start;
      logic done;
      logic mark;
   } dist_ctl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ricl_if.sv =====
// Valid/ready channel interfaces for point words and clique words.
`default_nettype none
interface ricl_req_if;
   import ricl_pkg::*;
   logic      valid;
   logic      ready;
   coord_type curr_x;
   coord_type curr_y;
   coord_type curr_z;
   coord_type prev_x;
   coord_type prev_y;
   coord_type prev_z;
   logic      last_point;

   modport source (output valid, curr_x, curr_y, curr_z, prev_x, prev_y, prev_z,
                   last_point, input ready);
   modport sink (input valid, curr_x, curr_y, curr_z, prev_x, prev_y, prev_z,
                 last_point, output ready);
endinterface

interface ricl_rsp_if;
   import ricl_pkg::*;
   logic              valid;
   logic              ready;
   logic [NODE_W-1:0] clique_node;
   logic              clique_last;

   modport source (output valid, clique_node, clique_last, input ready);
   modport sink (input valid, clique_node, clique_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ricl_dist.sv =====
// Shared distance unit: one squarer and a bit-serial square root, marks one pair.
`default_nettype none
module ricl_dist (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  ricl_pkg::point_type      pnt_a,
   input  ricl_pkg::point_type      pnt_b,
   input  logic [ricl_pkg::TOL_W-1:0] tol,
   output logic                     done,
   output logic                     mark
);
   import ricl_pkg::*;

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_MUL  = 2'd1;
   localparam logic [1:0] D_ROOT = 2'd2;

   logic [1:0]        state_ff;
   logic [2:0]        k_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  sum_c_ff, sum_p_ff;
   logic [SUM_W-1:0]  v_ff, res_ff, bit_ff;
   logic [4:0]        step_ff;
   logic              phase_ff;
   logic [ROOT_W-1:0] dc_ff;
   logic              done_ff, mark_ff;

   coord_type           op_a, op_b;
   logic signed [COORD_W:0] diff;
   logic [COORD_W:0]    mag_w;
   logic [MAG_W-1:0]    mag;
   logic [SUM_W-1:0]    trial, v_nx, res_nx;
   logic                ge;
   logic [ROOT_W-1:0]   root, adiff;

   always_comb begin
      case (k_ff)
         3'd0: begin op_a = pnt_a.cx; op_b = pnt_b.cx; end
         3'd1: begin op_a = pnt_a.cy; op_b = pnt_b.cy; end
         3'd2: begin op_a = pnt_a.cz; op_b = pnt_b.cz; end
         3'd3: begin op_a = pnt_a.px; op_b = pnt_b.px; end
         3'd4: begin op_a = pnt_a.py; op_b = pnt_b.py; end
         3'd5: begin op_a = pnt_a.pz; op_b = pnt_b.pz; end
         default: begin op_a = '0; op_b = '0; end
      endcase
      diff  = {op_a[COORD_W-1], op_a} - {op_b[COORD_W-1], op_b};
      mag_w = diff[COORD_W] ? 25'(-diff) : 25'(diff);
      mag   = mag_w[MAG_W-1:0];
   end

   // one restoring root step
   always_comb begin
      trial  = res_ff + bit_ff;
      ge     = (v_ff >= trial);
      v_nx   = ge ? (v_ff - trial) : v_ff;
      res_nx = ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      root   = res_nx[ROOT_W-1:0];
      adiff  = (dc_ff > root) ? (dc_ff - root) : (root - dc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  state_ff <= D_MUL;
                  k_ff     <= 3'd0;
                  sum_c_ff <= '0;
                  sum_p_ff <= '0;
               end
            end
            D_MUL: begin
               prod_ff <= mag * mag;
               if (k_ff != 3'd0) begin
                  if (k_ff <= 3'd3) sum_c_ff <= sum_c_ff + SUM_W'(prod_ff);
                  else sum_p_ff <= sum_p_ff + SUM_W'(prod_ff);
               end
               k_ff <= k_ff + 3'd1;
               if (k_ff == 3'd6) begin
                  state_ff <= D_ROOT;
                  v_ff     <= sum_c_ff;
                  res_ff   <= '0;
                  bit_ff   <= ROOT_BIT_INIT;
                  step_ff  <= '0;
                  phase_ff <= 1'b0;
               end
            end
            D_ROOT: begin
               v_ff    <= v_nx;
               res_ff  <= res_nx;
               bit_ff  <= bit_ff >> 2;
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(ROOT_STEPS - 1)) begin
                  if (!phase_ff) begin
                     dc_ff    <= root;
                     v_ff     <= sum_p_ff;
                     res_ff   <= '0;
                     bit_ff   <= ROOT_BIT_INIT;
                     step_ff  <= '0;
                     phase_ff <= 1'b1;
                  end else begin
                     mark_ff  <= (TOL_W'(adiff) < tol);
                     done_ff  <= 1'b1;
                     state_ff <= D_IDLE;
                  end
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign mark = mark_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ricl_point_mem.sv =====
// Point pair store: one write port, one registered read port.
`default_nettype none
module ricl_point_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ricl_pkg::point_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ricl_pkg::point_type rd_data
);
   import ricl_pkg::*;

   point_type mem [DEPTH];
   point_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rigidity_inlier_clique_search.sv =====
// Top level: point loading, consistency matrix build, greedy clique growth, output.
// A non-last word is stored while there is room. A last word starts the search:
// each of the N*N pairs goes through the shared distance unit (6 squares, two
// 25-step roots), then each growth round scans N rows; results are then offered
// one word at a time. Not ready from a last word until the final word is taken.
// Synchronous reset clears control state and sets the tolerance to 256.
`default_nettype none
module rigidity_inlier_clique_search #(
   parameter int MAX_POINTS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   ricl_req_if.sink                    req_chan,
   ricl_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ricl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [ricl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [ricl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import ricl_pkg::*;

   localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RDI  = 4'd1;
   localparam logic [3:0] ST_LATI = 4'd2;
   localparam logic [3:0] ST_RDJ  = 4'd3;
   localparam logic [3:0] ST_WAIT = 4'd4;
   localparam logic [3:0] ST_JRD  = 4'd5;
   localparam logic [3:0] ST_JOIN = 4'd6;
   localparam logic [3:0] ST_GRD  = 4'd7;
   localparam logic [3:0] ST_GCNT = 4'd8;
   localparam logic [3:0] ST_GDEC = 4'd9;
   localparam logic [3:0] ST_ORD  = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   logic [3:0]            state_ff;
   logic [TOL_W-1:0]      tol_ff;
   logic [CW-1:0]         count_ff, n_ff, members_ff, cnt_ff, best_ff, bc_ff;
   logic [IW-1:0]         i_ff, j_ff, e_ff, seed_ff, pick_ff;
   point_type             pi_ff;
   logic [MAX_POINTS-1:0] row_ff, cand_ff, row_rd_ff;
   logic [IW-1:0]         ord_rd_ff;

   logic [MAX_POINTS-1:0] row_mem [MAX_POINTS];
   logic [IW-1:0]         ord_mem [MAX_POINTS];

   dist_ctl_type          dctl;
   point_type             pt_wr, pt_rd;
   logic                  accept, pt_wr_en, pt_rd_en;
   logic [IW-1:0]         pt_rd_addr;
   logic                  row_rd_en, row_wr_en;
   logic [IW-1:0]         row_rd_addr;
   logic [MAX_POINTS-1:0] row_in, masked, pick_bit;
   logic [CW-1:0]         cnt_in, pc;
   logic                  csr_wr;

   // csr
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TOLERANCE) ? CSR_DW'(tol_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_wr && csr_paddr[2] == REG_TOLERANCE) tol_ff <= csr_pwdata[TOL_W-1:0];
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;

   assign pt_wr.cx = req_chan.curr_x;
   assign pt_wr.cy = req_chan.curr_y;
   assign pt_wr.cz = req_chan.curr_z;
   assign pt_wr.px = req_chan.prev_x;
   assign pt_wr.py = req_chan.prev_y;
   assign pt_wr.pz = req_chan.prev_z;
   assign pt_wr_en   = accept && (count_ff < MAXC);
   assign pt_rd_en   = (state_ff == ST_RDI) || (state_ff == ST_RDJ);
   assign pt_rd_addr = (state_ff == ST_RDI) ? i_ff : j_ff;

   ricl_point_mem #(.DEPTH(MAX_POINTS), .AW(IW)) u_pts (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data (pt_wr),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd)
   );

   assign dctl.start = (state_ff == ST_RDJ);

   ricl_dist u_dist (
      .clock (clock),
      .reset (reset),
      .start (dctl.start),
      .pnt_a (pi_ff),
      .pnt_b (pt_rd),
      .tol   (tol_ff),
      .done  (dctl.done),
      .mark  (dctl.mark)
   );

   always_comb begin
      row_in = row_ff;
      row_in[j_ff] = dctl.mark;
      cnt_in = cnt_ff + CW'(dctl.mark);
      pick_bit = '0;
      pick_bit[pick_ff] = 1'b1;
      masked = row_rd_ff & cand_ff;
      pc = '0;
      for (int b = 0; b < MAX_POINTS; b++) pc = pc + CW'(masked[b]);
   end

   assign row_wr_en   = (state_ff == ST_WAIT) && dctl.done &&
                        (CW'(j_ff) == n_ff - CW'(1));
   assign row_rd_en   = (state_ff == ST_JRD) || (state_ff == ST_GRD);
   assign row_rd_addr = (state_ff == ST_JRD) ? pick_ff : i_ff;

   always_ff @(posedge clock) begin
      if (row_wr_en) row_mem[i_ff] <= row_in;
      if (row_rd_en) row_rd_ff <= row_mem[row_rd_addr];
      if (state_ff == ST_JOIN) ord_mem[members_ff[IW-1:0]] <= pick_ff;
      if (state_ff == ST_ORD) ord_rd_ff <= ord_mem[e_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (count_ff < MAXC) count_ff <= count_ff + CW'(1);
                  if (req_chan.last_point) begin
                     n_ff     <= (count_ff < MAXC) ? count_ff + CW'(1) : count_ff;
                     count_ff <= '0;
                     i_ff     <= '0;
                     best_ff  <= '0;
                     seed_ff  <= '0;
                     state_ff <= ST_RDI;
                  end
               end
            end
            ST_RDI: state_ff <= ST_LATI;
            ST_LATI: begin
               pi_ff    <= pt_rd;
               row_ff   <= '0;
               cnt_ff   <= '0;
               j_ff     <= '0;
               state_ff <= ST_RDJ;
            end
            ST_RDJ: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (dctl.done) begin
                  row_ff <= row_in;
                  cnt_ff <= cnt_in;
                  if (CW'(j_ff) == n_ff - CW'(1)) begin
                     // first row with the most marks seeds the clique
                     if (cnt_in > best_ff) begin
                        best_ff <= cnt_in;
                        seed_ff <= i_ff;
                     end
                     if (CW'(i_ff) == n_ff - CW'(1)) begin
                        pick_ff    <= (cnt_in > best_ff) ? i_ff : seed_ff;
                        members_ff <= '0;
                        state_ff   <= ST_JRD;
                     end else begin
                        i_ff     <= i_ff + IW'(1);
                        state_ff <= ST_RDI;
                     end
                  end else begin
                     j_ff     <= j_ff + IW'(1);
                     state_ff <= ST_RDJ;
                  end
               end
            end
            ST_JRD: state_ff <= ST_JOIN;
            ST_JOIN: begin
               if (members_ff == '0) cand_ff <= row_rd_ff & ~pick_bit;
               else cand_ff <= cand_ff & row_rd_ff & ~pick_bit;
               members_ff <= members_ff + CW'(1);
               i_ff       <= '0;
               bc_ff      <= '0;
               e_ff       <= '0;
               if (members_ff + CW'(1) < n_ff) state_ff <= ST_GRD;
               else state_ff <= ST_ORD;
            end
            ST_GRD: state_ff <= ST_GCNT;
            ST_GCNT: begin
               if (cand_ff[i_ff] && pc > bc_ff) begin
                  bc_ff   <= pc;
                  pick_ff <= i_ff;
               end
               if (CW'(i_ff) == n_ff - CW'(1)) state_ff <= ST_GDEC;
               else begin
                  i_ff     <= i_ff + IW'(1);
                  state_ff <= ST_GRD;
               end
            end
            ST_GDEC: state_ff <= (bc_ff == '0) ? ST_ORD : ST_JRD;
            ST_ORD: state_ff <= ST_OUT;
            ST_OUT: begin
               if (rsp_chan.ready) begin
                  if (CW'(e_ff) == members_ff - CW'(1)) state_ff <= ST_IDLE;
                  else begin
                     e_ff     <= e_ff + IW'(1);
                     state_ff <= ST_ORD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.clique_node = NODE_W'(ord_rd_ff);
   assign rsp_chan.clique_last = (CW'(e_ff) == members_ff - CW'(1));

endmodule
`default_nettype wire
